@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for the clocked concurrent assertions used by the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/dmcq_pkg.sv @@
// ----------------------------------------------------------------------------
// dmcq_pkg
// Types, register indexes, reset values and helpers of the contact qualifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmcq_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SLOW_RELEASE = 3'd0,
    REG_WINDOW       = 3'd1,
    REG_THRESHOLD    = 3'd2,
    REG_CAP          = 3'd3,
    REG_SAMPLE       = 3'd4,
    REG_FAST         = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_UNDET  = 2'd0,
    ST_OPEN   = 2'd1,
    ST_CLOSED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] slow_release_ticks;
    logic [7:0] window_ticks;
    logic [5:0] pulse_threshold;
    logic [5:0] pulse_cap;
    logic [3:0] pulse_sample_ticks;
    logic [7:0] fast_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    slow_release_ticks: 8'd200,
    window_ticks:       8'd200,
    pulse_threshold:    6'd20,
    pulse_cap:          6'd50,
    pulse_sample_ticks: 4'd3,
    fast_ticks:         8'd5
  };

  typedef struct packed {
    logic [7:0] open_run;
    logic [7:0] active_run;
    logic       open_accepted;
    logic       closed_accepted;
    logic       window_open;
    logic [7:0] window_elapsed;
    logic [5:0] pulse_total;
    status_t    status;
  } qual_state_t;

  localparam qual_state_t STATE_RESET = '{
    open_run:        8'd0,
    active_run:      8'd0,
    open_accepted:   1'b0,
    closed_accepted: 1'b0,
    window_open:     1'b0,
    window_elapsed:  8'd0,
    pulse_total:     6'd0,
    status:          ST_UNDET
  };

  // Increment that sticks at all ones.
  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

@@ sv/dmcq_in_if.sv @@
// ----------------------------------------------------------------------------
// dmcq_in_if
// Tick channel: mode pin and sensor pin levels sampled once per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmcq_in_if;
  logic valid;
  logic ready;
  logic slow_mode;
  logic sensor_active;

  modport source (output valid, output slow_mode, output sensor_active, input ready);
  modport sink   (input valid, input slow_mode, input sensor_active, output ready);
endinterface

@@ sv/dmcq_out_if.sv @@
// ----------------------------------------------------------------------------
// dmcq_out_if
// Result channel: qualified sensor status and settled flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmcq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] sensor_state;
  logic       sleep_ok;

  modport source (output valid, output sensor_state, output sleep_ok, input ready);
  modport sink   (input valid, input sensor_state, input sleep_ok, output ready);
endinterface

@@ sv/dmcq_cfg_if.sv @@
// ----------------------------------------------------------------------------
// dmcq_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmcq_cfg_if;
  import dmcq_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/dual_mode_contact_qualifier.sv @@
// ----------------------------------------------------------------------------
// dual_mode_contact_qualifier
// Contact sensor qualifier: fast debounce or slow windowed pulse counting.
// ----------------------------------------------------------------------------
// Usage:
//   sense  : one beat per 10 ms tick, carrying the mode and sensor pin levels.
//   result : one beat per tick, the qualified status (0 undetermined,
//            1 open, 2 closed) and sleep_ok, set when the pin level matches
//            the state already accepted.
//   cfg    : register writes by index; always ready. Write only while idle.
// Throughput: one tick per cycle while the result channel is not stalled.
//   The qualifier state updates in one pass of the core logic and the
//   result lands in a single output register.
// Stall: while a result waits unaccepted, sense.ready is low; the next tick
//   is taken in the same cycle the waiting result is taken.
// Reset: registers return to their reset values, counters clear, status goes
//   to undetermined and the output register empties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_mode_contact_qualifier
  import dmcq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  dmcq_cfg_if.sink   cfg,
  dmcq_in_if.sink    sense,
  dmcq_out_if.source result
);

  cfg_t        cfg_regs;
  qual_state_t st;
  qual_state_t st_next;
  logic        sleep_next;
  logic        take;

  assign cfg.ready   = 1'b1;
  assign sense.ready = !result.valid || result.ready;
  assign take        = sense.valid && sense.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= CFG_RESET;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_SLOW_RELEASE: cfg_regs.slow_release_ticks <= cfg.data;
        REG_WINDOW:       cfg_regs.window_ticks       <= cfg.data;
        REG_THRESHOLD:    cfg_regs.pulse_threshold    <= cfg.data[5:0];
        REG_CAP:          cfg_regs.pulse_cap          <= cfg.data[5:0];
        REG_SAMPLE:       cfg_regs.pulse_sample_ticks <= cfg.data[3:0];
        REG_FAST:         cfg_regs.fast_ticks         <= cfg.data;
        default: ;
      endcase
    end
  end

  dmcq_core u_core (
    .cfg           (cfg_regs),
    .st            (st),
    .slow_mode     (sense.slow_mode),
    .sensor_active (sense.sensor_active),
    .st_next       (st_next),
    .sleep_ok      (sleep_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (take) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.sensor_state <= st_next.status;
      result.sleep_ok     <= sleep_next;
    end
  end

endmodule

@@ sv/dmcq_core.sv @@
// ----------------------------------------------------------------------------
// dmcq_core
// Per-tick next-state and result logic of the contact qualifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmcq_core
  import dmcq_pkg::*;
(
  input  cfg_t        cfg,
  input  qual_state_t st,
  input  logic        slow_mode,
  input  logic        sensor_active,
  output qual_state_t st_next,
  output logic        sleep_ok
);

  always_comb begin
    st_next  = st;
    sleep_ok = 1'b0;

    if (!sensor_active) begin
      st_next.active_run = 8'd0;
      if (!st.open_accepted) begin
        st_next.open_run = sat_inc(st.open_run);
        if (st_next.open_run >= (slow_mode ? cfg.slow_release_ticks : cfg.fast_ticks)) begin
          st_next.status          = ST_OPEN;
          st_next.open_accepted   = 1'b1;
          st_next.closed_accepted = 1'b0;
        end
      end else begin
        sleep_ok = 1'b1;
      end
    end else begin
      st_next.open_run = 8'd0;
      if (!st.closed_accepted) begin
        st_next.active_run = sat_inc(st.active_run);
        if (slow_mode) begin
          st_next.window_open = 1'b1;
          if (st_next.active_run >= {4'd0, cfg.pulse_sample_ticks}) begin
            st_next.active_run = 8'd0;
            // below the cap, so the increment cannot wrap
            if (st.pulse_total < cfg.pulse_cap) begin
              st_next.pulse_total = st.pulse_total + 6'd1;
            end
          end
        end else if (st_next.active_run >= cfg.fast_ticks) begin
          st_next.active_run      = 8'd0;
          st_next.status          = ST_CLOSED;
          st_next.closed_accepted = 1'b1;
          st_next.open_accepted   = 1'b0;
        end
      end else begin
        sleep_ok = 1'b1;
      end
    end

    // Window bookkeeping is frozen in fast mode.
    if (slow_mode) begin
      if (st_next.window_open) begin
        st_next.window_elapsed = sat_inc(st.window_elapsed);
        if (st_next.window_elapsed >= cfg.window_ticks) begin
          st_next.window_elapsed = 8'd0;
          st_next.window_open    = 1'b0;
          if (st_next.pulse_total >= cfg.pulse_threshold) begin
            st_next.pulse_total     = 6'd0;
            st_next.status          = ST_CLOSED;
            st_next.closed_accepted = 1'b1;
            st_next.open_accepted   = 1'b0;
          end
        end
      end else begin
        st_next.window_elapsed = 8'd0;
      end
    end
  end

endmodule

@@ sv/dmcq_checker.sv @@
// ----------------------------------------------------------------------------
// dmcq_checker
// Port-level checks of the contact qualifier, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmcq_checker
  import dmcq_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] sensor_state,
  input logic       sleep_ok
);

  // A waiting result must not be overwritten by a new tick.
  `ASSERT_SAME(a_no_take_on_stall, clk, rst, out_valid && !out_ready, !in_ready)
  // Every accepted tick yields a result beat next cycle.
  `ASSERT_NEXT(a_tick_gives_beat, clk, rst, in_valid && in_ready, out_valid)
  // Stalled result holds its payload.
  `ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready,
               out_valid && $stable(sensor_state) && $stable(sleep_ok))
  // Settled only once some state has been accepted.
  `ASSERT_SAME(a_sleep_needs_state, clk, rst, out_valid && sleep_ok,
               sensor_state != ST_UNDET)

endmodule

bind dual_mode_contact_qualifier dmcq_checker u_dmcq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sense.valid),
  .in_ready     (sense.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .sensor_state (result.sensor_state),
  .sleep_ok     (result.sleep_ok)
);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dual mode contact qualifier. A directed table
// covers reset, zero and all-ones register settings and both modes; random
// register settings and level runs follow. Each result beat is checked against
// its row's result or a shadow qualifier model, with random idles on both channels.
// ----------------------------------------------------------------------------

module tb;
  import dmcq_pkg::*;

  localparam int TickGoal   = 600;
  localparam int CycleLimit = 200000;

  // Indexes past the last register; writes to them must be dropped.
  localparam logic [CfgIdxW-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_HI = 3'd7;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct packed {
    status_t state;
    logic    sleep;
  } tick_result_t;

  typedef struct {
    row_kind_t            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic                 slow;
    logic                 act;
    logic                 typed;
    tick_result_t         res;
  } stim_row_t;

  localparam tick_result_t NO_RES = '{ST_UNDET, 1'b0};

  stim_row_t directed [37] = '{
    // fast mode, reset settings: open after five open ticks, then closed
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, 1'b1, '{ST_UNDET, 1'b0}},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, 1'b1, '{ST_UNDET, 1'b0}},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, 1'b1, '{ST_UNDET, 1'b0}},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, 1'b1, '{ST_UNDET, 1'b0}},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, 1'b1, '{ST_OPEN, 1'b0}},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, 1'b1, '{ST_OPEN, 1'b1}},
    '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b1, '{ST_OPEN, 1'b0}},
    '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b1, '{ST_OPEN, 1'b0}},
    '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b1, '{ST_OPEN, 1'b0}},
    '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b1, '{ST_OPEN, 1'b0}},
    '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b1, '{ST_CLOSED, 1'b0}},
    '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b1, '{ST_CLOSED, 1'b1}},
    // zero limits fire on the first tick; unused indexes must be dropped
    '{ROW_CFG, REG_SLOW_RELEASE, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_WINDOW,       8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_THRESHOLD,    8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_CAP,          8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_SAMPLE,       8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_FAST,         8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_UNUSED_LO,    8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_UNUSED_HI,    8'hA5, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_TICK, '0, '0, 1'b1, 1'b0, 1'b1, '{ST_OPEN, 1'b0}},
    '{ROW_TICK, '0, '0, 1'b1, 1'b1, 1'b1, '{ST_CLOSED, 1'b0}},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, 1'b1, '{ST_OPEN, 1'b0}},
    '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b1, '{ST_CLOSED, 1'b0}},
    '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b1, '{ST_CLOSED, 1'b1}},
    // all ones; upper data bits must be masked off the narrow registers
    '{ROW_CFG, REG_SLOW_RELEASE, 8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_WINDOW,       8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_THRESHOLD,    8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_CAP,          8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_SAMPLE,       8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_FAST,         8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_TICK, '0, '0, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_TICK, '0, '0, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_TICK, '0, '0, 1'b1, 1'b1, 1'b0, NO_RES},
    '{ROW_TICK, '0, '0, 1'b1, 1'b1, 1'b0, NO_RES},
    '{ROW_TICK, '0, '0, 1'b1, 1'b1, 1'b0, NO_RES},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst;

  dmcq_in_if  sense_if ();
  dmcq_out_if result_if ();
  dmcq_cfg_if cfg_if ();

  dual_mode_contact_qualifier u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .sense  (sense_if),
    .result (result_if)
  );

  always #5 clk = ~clk;

  // shadow copy of the qualifier
  cfg_t         shadow_cfg = CFG_RESET;
  qual_state_t  shadow_st  = STATE_RESET;
  tick_result_t pending_results [$];

  int           errors      = 0;
  int           cycle_count = 0;
  int           ticks_taken = 0;
  logic         calm;
  logic         row_typed;
  tick_result_t row_res;

  assign calm = (ticks_taken >= 220) && (ticks_taken < 360);

  function automatic tick_result_t qualify_tick(input logic slow, input logic act);
    qual_state_t  s;
    tick_result_t r;
    s = shadow_st;
    r.sleep = 1'b0;
    if (!act) begin
      s.active_run = '0;
      if (!s.open_accepted) begin
        if (s.open_run != 8'hFF) s.open_run = s.open_run + 8'd1;
        if (s.open_run >= (slow ? shadow_cfg.slow_release_ticks : shadow_cfg.fast_ticks)) begin
          s.status          = ST_OPEN;
          s.open_accepted   = 1'b1;
          s.closed_accepted = 1'b0;
        end
      end else begin
        r.sleep = 1'b1;
      end
    end else begin
      s.open_run = '0;
      if (!s.closed_accepted) begin
        if (s.active_run != 8'hFF) s.active_run = s.active_run + 8'd1;
        if (slow) begin
          s.window_open = 1'b1;
          if (s.active_run >= shadow_cfg.pulse_sample_ticks) begin
            s.active_run = '0;
            if (s.pulse_total < shadow_cfg.pulse_cap) s.pulse_total = s.pulse_total + 6'd1;
          end
        end else if (s.active_run >= shadow_cfg.fast_ticks) begin
          s.active_run      = '0;
          s.status          = ST_CLOSED;
          s.closed_accepted = 1'b1;
          s.open_accepted   = 1'b0;
        end
      end else begin
        r.sleep = 1'b1;
      end
    end
    // window only advances in slow mode; fast mode freezes it
    if (slow) begin
      if (s.window_open) begin
        if (s.window_elapsed != 8'hFF) s.window_elapsed = s.window_elapsed + 8'd1;
        if (s.window_elapsed >= shadow_cfg.window_ticks) begin
          s.window_elapsed = '0;
          s.window_open    = 1'b0;
          if (s.pulse_total >= shadow_cfg.pulse_threshold) begin
            s.pulse_total     = '0;
            s.status          = ST_CLOSED;
            s.closed_accepted = 1'b1;
            s.open_accepted   = 1'b0;
          end
        end
      end else begin
        s.window_elapsed = '0;
      end
    end
    shadow_st = s;
    r.state   = s.status;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    tick_result_t want;
    tick_result_t got;
    cycle_count++;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, state=%0d sleep_ok=%0b", $time,
                   result_if.sensor_state, result_if.sleep_ok);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (result_if.sensor_state !== want.state) begin
            $display("%0t: sensor_state expected %0d, got %0d", $time, want.state,
                     result_if.sensor_state);
            errors++;
          end
          if (result_if.sleep_ok !== want.sleep) begin
            $display("%0t: sleep_ok expected %0b, got %0b", $time, want.sleep,
                     result_if.sleep_ok);
            errors++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_SLOW_RELEASE: shadow_cfg.slow_release_ticks = cfg_if.data;
          REG_WINDOW:       shadow_cfg.window_ticks       = cfg_if.data;
          REG_THRESHOLD:    shadow_cfg.pulse_threshold    = cfg_if.data[5:0];
          REG_CAP:          shadow_cfg.pulse_cap          = cfg_if.data[5:0];
          REG_SAMPLE:       shadow_cfg.pulse_sample_ticks = cfg_if.data[3:0];
          REG_FAST:         shadow_cfg.fast_ticks         = cfg_if.data;
          default: ;
        endcase
      end
      if (sense_if.valid && sense_if.ready) begin
        got = qualify_tick(sense_if.slow_mode, sense_if.sensor_active);
        pending_results.push_back(row_typed ? row_res : got);
        ticks_taken++;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) result_if.ready <= calm || ($urandom_range(0, 99) >= 17);
  end

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_tick(input logic s, input logic a, input logic typed,
                           input tick_result_t res);
    cfg_if.valid <= 1'b0;
    while (!calm && $urandom_range(0, 99) < 17) begin
      sense_if.valid <= 1'b0;
      @(negedge clk);
    end
    row_typed = typed;
    row_res   = res;
    sense_if.slow_mode     <= s;
    sense_if.sensor_active <= a;
    sense_if.valid         <= 1'b1;
    do @(posedge clk); while (!sense_if.ready);
    @(negedge clk);
  endtask

  // register writes only once every pending result has drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    sense_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int         n_rand;
    int         left;
    int         run_len;
    logic       phase_slow;
    logic       level;
    logic       s;
    logic       a;
    logic [7:0] val;
    logic [7:0] mask;
    rst                    = 1'b1;
    row_typed              = 1'b0;
    row_res                = NO_RES;
    sense_if.valid         = 1'b0;
    sense_if.slow_mode     = 1'b0;
    sense_if.sensor_active = 1'b0;
    result_if.ready        = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = '0;
    cfg_if.data            = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_tick(directed[i].slow, directed[i].act, directed[i].typed, directed[i].res);
      end
    end

    n_rand = 0;
    while (n_rand < TickGoal) begin
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, 8'($urandom));
      end
      for (int r = REG_SLOW_RELEASE; r <= REG_FAST; r++) begin
        case (reg_idx_t'(r))
          REG_THRESHOLD, REG_CAP: begin
            mask = 8'h3F;
            val  = 8'($urandom_range(0, 8));
          end
          REG_SAMPLE: begin
            mask = 8'h0F;
            val  = 8'($urandom_range(1, 4));
          end
          default: begin
            mask = 8'hFF;
            val  = 8'($urandom_range(1, 16));
          end
        endcase
        // now and then a zero or an all-ones setting
        case ($urandom_range(0, 9))
          0: val = 8'h00;
          1: val = mask;
          default: ;
        endcase
        write_reg(r[CfgIdxW-1:0], (val & mask) | (8'($urandom) & ~mask));
      end

      // runs of one pin level, mostly in one mode, with stray ticks mixed in
      phase_slow = 1'($urandom_range(0, 1));
      level      = 1'($urandom_range(0, 1));
      left       = $urandom_range(40, 80);
      while (left > 0) begin
        level = ~level;
        if ($urandom_range(0, 29) == 0) begin
          run_len = $urandom_range(200, 270);
          left    = left + run_len;
        end else begin
          run_len = $urandom_range(1, 24);
        end
        while (run_len > 0 && left > 0) begin
          s = ($urandom_range(0, 19) == 0) ? ~phase_slow : phase_slow;
          a = ($urandom_range(0, 24) == 0) ? ~level : level;
          send_tick(s, a, 1'b0, NO_RES);
          run_len--;
          left--;
          n_rand++;
        end
      end
    end

    sense_if.valid <= 1'b0;
    cfg_if.valid   <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("[dual_mode_contact_qualifier] OK");
    end else begin
      $display("[dual_mode_contact_qualifier] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("[dual_mode_contact_qualifier] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/dmcq_pkg.sv
sv/dmcq_in_if.sv
sv/dmcq_out_if.sv
sv/dmcq_cfg_if.sv
sv/dmcq_core.sv
sv/dual_mode_contact_qualifier.sv
sv/dmcq_checker.sv
sim/tb.sv
